/* rtl/swpwr_pkg.sv */
// Package for the single-wire pulse-width receiver.
// Holds payload, configuration and state types and the reset values of the limits.
// Used by the channel interfaces and by every module of the receiver.
`timescale 1ns / 1ps

package swpwr_pkg;

  localparam int unsigned MaxMessageBytes = 16;
  localparam int unsigned LenWidth        = $clog2(MaxMessageBytes + 1);
  localparam int unsigned CfgDataWidth    = 16;
  localparam int unsigned CfgIndexWidth   = 3;

  // register indexes of the configuration port
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_ONE_LOW_MAX            = 3'd0,
    CFG_ZERO_LOW_MAX           = 3'd1,
    CFG_ONE_RECOVERY_MAX       = 3'd2,
    CFG_ZERO_RECOVERY_MAX      = 3'd3,
    CFG_ONE_STOP_RECOVERY_MAX  = 3'd4,
    CFG_ZERO_STOP_RECOVERY_MAX = 3'd5,
    CFG_MESSAGE_LENGTH         = 3'd6
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_e;

  typedef struct packed {
    logic [15:0] one_low_max;
    logic [15:0] zero_low_max;
    logic [15:0] one_recovery_max;
    logic [15:0] zero_recovery_max;
    logic [15:0] one_stop_recovery_max;
    logic [15:0] zero_stop_recovery_max;
    logic [4:0]  message_length;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    one_low_max:            16'd24,
    zero_low_max:           16'd64,
    one_recovery_max:       16'd72,
    zero_recovery_max:      16'd32,
    one_stop_recovery_max:  16'd168,
    zero_stop_recovery_max: 16'd128,
    message_length:         5'd4
  };

  typedef struct packed {
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] byte_index;
    logic       last_byte;
    logic       timing_error;
  } out_item_t;

  // decoder result for one sample: a byte completed or not
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } dec_result_t;

endpackage

/* rtl/swpwr_in_if.sv */
// Input channel of the receiver: valid/ready handshake carrying one line sample.
// Depends on swpwr_pkg for the payload type.
`timescale 1ns / 1ps

interface swpwr_in_if;
  import swpwr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/swpwr_out_if.sv */
// Output channel of the receiver: valid/ready handshake carrying one decoded byte.
// Depends on swpwr_pkg for the payload type.
`timescale 1ns / 1ps

interface swpwr_out_if;
  import swpwr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/swpwr_decoder.sv */
// Bit timing decoder: phase, duration counter and byte assembly state.
// Advances one sample per step and reports a completed byte combinationally.
// Depends on swpwr_pkg.
`timescale 1ns / 1ps

module swpwr_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  level_i,
  input  swpwr_pkg::cfg_t       cfg_i,
  output swpwr_pkg::dec_result_t result_o
);
  import swpwr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic        bit_value_q, bit_value_d;
  logic [2:0]  bit_pos_q, bit_pos_d;
  logic [7:0]  shift_q, shift_d;
  logic [3:0]  bytes_done_q, bytes_done_d;
  logic        error_q, error_d;
  logic        prev_level_q;

  logic [15:0]         low_limit;
  logic [15:0]         rec_limit;
  logic                finish;
  logic                good;
  logic                bit_in;
  logic                err_now;
  logic [7:0]          shift_now;
  logic [LenWidth-1:0] msg_len;
  logic [LenWidth-1:0] done_plus;
  logic                last;

  assign low_limit = (cfg_i.one_low_max > cfg_i.zero_low_max) ? cfg_i.one_low_max
                                                               : cfg_i.zero_low_max;

  always_comb begin
    if (bit_pos_q == 3'd7) begin
      rec_limit = bit_value_q ? cfg_i.one_stop_recovery_max : cfg_i.zero_stop_recovery_max;
    end else begin
      rec_limit = bit_value_q ? cfg_i.one_recovery_max : cfg_i.zero_recovery_max;
    end
  end

  // message length of zero acts as one, above the maximum as the maximum
  always_comb begin
    if (cfg_i.message_length == '0) begin
      msg_len = LenWidth'(1);
    end else if (LenWidth'(cfg_i.message_length) > LenWidth'(MaxMessageBytes)) begin
      msg_len = LenWidth'(MaxMessageBytes);
    end else begin
      msg_len = LenWidth'(cfg_i.message_length);
    end
  end

  // phase and duration
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    bit_value_d = bit_value_q;
    finish      = 1'b0;
    good        = 1'b1;
    case (phase_q)
      PH_IDLE: begin
        if (prev_level_q && !level_i) begin
          phase_d = PH_LOW;
          count_d = 16'd1;
        end
      end
      PH_LOW: begin
        if (!level_i) begin
          if (count_q >= low_limit) begin
            bit_value_d = 1'b0;
            finish      = 1'b1;
            good        = 1'b0;
            phase_d     = PH_IDLE;
            count_d     = '0;
          end else begin
            count_d = count_q + 16'd1;
          end
        end else if (count_q <= cfg_i.one_low_max) begin
          bit_value_d = 1'b1;
          phase_d     = PH_HIGH;
          count_d     = 16'd1;
        end else if (count_q <= cfg_i.zero_low_max) begin
          bit_value_d = 1'b0;
          phase_d     = PH_HIGH;
          count_d     = 16'd1;
        end else begin
          bit_value_d = 1'b0;
          finish      = 1'b1;
          good        = 1'b0;
          phase_d     = PH_IDLE;
          count_d     = '0;
        end
      end
      default: begin
        if (level_i) begin
          if (count_q >= rec_limit) begin
            finish  = 1'b1;
            good    = 1'b0;
            phase_d = PH_IDLE;
            count_d = '0;
          end else begin
            count_d = count_q + 16'd1;
          end
        end else begin
          finish  = 1'b1;
          good    = (count_q <= rec_limit);
          phase_d = PH_LOW;
          count_d = 16'd1;
        end
      end
    endcase
  end

  // bit store and byte completion
  assign err_now   = error_q | ~good;
  assign bit_in    = good & ~error_q & bit_value_d;
  assign shift_now = shift_q | (8'(bit_in) << bit_pos_q);
  assign done_plus = LenWidth'(bytes_done_q) + LenWidth'(1);
  assign last      = (done_plus >= msg_len);

  always_comb begin
    bit_pos_d       = bit_pos_q;
    shift_d         = shift_q;
    bytes_done_d    = bytes_done_q;
    error_d         = error_q;
    result_o.valid  = 1'b0;
    result_o.item.data_byte    = shift_now;
    result_o.item.byte_index   = bytes_done_q;
    result_o.item.last_byte    = last;
    result_o.item.timing_error = err_now;
    if (finish) begin
      error_d = err_now;
      if (bit_pos_q != 3'd7) begin
        shift_d   = shift_now;
        bit_pos_d = bit_pos_q + 3'd1;
      end else begin
        result_o.valid = 1'b1;
        shift_d        = '0;
        bit_pos_d      = '0;
        if (last) begin
          bytes_done_d = '0;
          error_d      = 1'b0;
        end else begin
          bytes_done_d = bytes_done_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      bit_value_q  <= 1'b0;
      bit_pos_q    <= '0;
      shift_q      <= '0;
      bytes_done_q <= '0;
      error_q      <= 1'b0;
      prev_level_q <= 1'b1;
    end else if (step_i) begin
      phase_q      <= phase_d;
      count_q      <= count_d;
      bit_value_q  <= bit_value_d;
      bit_pos_q    <= bit_pos_d;
      shift_q      <= shift_d;
      bytes_done_q <= bytes_done_d;
      error_q      <= error_d;
      prev_level_q <= level_i;
    end
  end

endmodule

/* rtl/single_wire_pulse_width_receiver_unit.sv */
// Single-wire pulse-width receiver: one line sample per cycle while the byte side does not stall,
// one byte result per eight bits. A sample passes an input register, then the decoder,
// and its byte is then registered in the output register.
// A stalled byte holds the decoder, and an empty input register still
// takes one sample while a byte waits.
// Reset (rst_ni, asynchronous, active low) clears the pipeline and decoder state and loads
// the limit registers with their default values.
`timescale 1ns / 1ps

module single_wire_pulse_width_receiver_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swpwr_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [swpwr_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  swpwr_in_if.sink                             in_i,
  swpwr_out_if.source                          out_o
);
  import swpwr_pkg::*;

  cfg_t        cfg_q;
  logic        s1_valid_q;
  logic        s1_level_q;
  logic        out_valid_q;
  out_item_t   out_data_q;
  logic        advance;
  logic        step;
  logic        in_xfer;
  dec_result_t dec_res;

  assign advance  = ~out_valid_q | out_o.ready;
  assign in_i.ready = advance | ~s1_valid_q;
  assign in_xfer  = in_i.valid & in_i.ready;
  assign step     = s1_valid_q & advance;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_ONE_LOW_MAX:            cfg_q.one_low_max            <= cfg_wdata_i;
        CFG_ZERO_LOW_MAX:           cfg_q.zero_low_max           <= cfg_wdata_i;
        CFG_ONE_RECOVERY_MAX:       cfg_q.one_recovery_max       <= cfg_wdata_i;
        CFG_ZERO_RECOVERY_MAX:      cfg_q.zero_recovery_max      <= cfg_wdata_i;
        CFG_ONE_STOP_RECOVERY_MAX:  cfg_q.one_stop_recovery_max  <= cfg_wdata_i;
        CFG_ZERO_STOP_RECOVERY_MAX: cfg_q.zero_stop_recovery_max <= cfg_wdata_i;
        CFG_MESSAGE_LENGTH:         cfg_q.message_length         <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_level_q <= in_i.data.line_level;
    end
  end

  swpwr_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (s1_level_q),
    .cfg_i    (cfg_q),
    .result_o (dec_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step & dec_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step && dec_res.valid) begin
      out_data_q <= dec_res.item;
    end
  end

endmodule

/* tb/sv/swpwr_byte_checker.sv */
// Checker for the single-wire pulse-width receiver: follows register writes and line sample
// transfers, decodes the expected bytes itself and compares every byte transfer with them.
// Depends on swpwr_pkg and the swpwr_in_if / swpwr_out_if channel interfaces.
`timescale 1ns / 1ps

module swpwr_byte_checker
  import swpwr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i,
  swpwr_in_if                      line_i,
  swpwr_out_if                     byte_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  cfg_t        lim;
  phase_e      ph;
  logic [15:0] dur;
  logic        bval;
  logic [2:0]  bpos;
  logic [7:0]  sbyte;
  logic [3:0]  bdone;
  logic        err;
  logic        prev;
  out_item_t   decoded_bytes[$];

  function automatic logic [15:0] low_ceiling();
    return (lim.one_low_max > lim.zero_low_max) ? lim.one_low_max : lim.zero_low_max;
  endfunction

  // the eighth bit of a byte gets the stop recovery limit
  function automatic logic [15:0] recovery_ceiling();
    if (bpos == 3'd7) begin
      return bval ? lim.one_stop_recovery_max : lim.zero_stop_recovery_max;
    end
    return bval ? lim.one_recovery_max : lim.zero_recovery_max;
  endfunction

  function automatic void close_bit(input logic good);
    int unsigned span;
    logic        v;
    out_item_t   res;
    v = 1'b0;
    if (!good) begin
      err = 1'b1;
    end else if (!err) begin
      v = bval;
    end
    sbyte[bpos] = sbyte[bpos] | v;
    if (bpos != 3'd7) begin
      bpos++;
      return;
    end
    span = 32'(lim.message_length);
    if (span == 0) span = 1;
    if (span > MaxMessageBytes) span = MaxMessageBytes;
    res.data_byte    = sbyte;
    res.byte_index   = bdone;
    res.last_byte    = (int'(bdone) + 1 >= span);
    res.timing_error = err;
    decoded_bytes.push_back(res);
    // sticky error and byte count restart with each message
    if (res.last_byte) begin
      bdone = '0;
      err   = 1'b0;
    end else begin
      bdone++;
    end
    sbyte = '0;
    bpos  = '0;
  endfunction

  function automatic void decode_sample(input logic lvl);
    case (ph)
      PH_IDLE: begin
        if (prev && !lvl) begin
          ph  = PH_LOW;
          dur = 16'd1;
        end
      end
      PH_LOW: begin
        if (!lvl) begin
          if (dur >= low_ceiling()) begin
            bval = 1'b0;
            close_bit(1'b0);
            ph  = PH_IDLE;
            dur = '0;
          end else begin
            dur++;
          end
        end else if (dur <= lim.one_low_max) begin
          bval = 1'b1;
          ph   = PH_HIGH;
          dur  = 16'd1;
        end else if (dur <= lim.zero_low_max) begin
          bval = 1'b0;
          ph   = PH_HIGH;
          dur  = 16'd1;
        end else begin
          bval = 1'b0;
          close_bit(1'b0);
          ph  = PH_IDLE;
          dur = '0;
        end
      end
      default: begin
        if (lvl) begin
          if (dur >= recovery_ceiling()) begin
            close_bit(1'b0);
            ph  = PH_IDLE;
            dur = '0;
          end else begin
            dur++;
          end
        end else begin
          // falling edge closes this bit and opens the next one
          close_bit(dur <= recovery_ceiling());
          ph  = PH_LOW;
          dur = 16'd1;
        end
      end
    endcase
    prev = lvl;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      lim   = CfgReset;
      ph    = PH_IDLE;
      dur   = '0;
      bval  = 1'b0;
      bpos  = '0;
      sbyte = '0;
      bdone = '0;
      err   = 1'b0;
      prev  = 1'b1;
      decoded_bytes.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_ONE_LOW_MAX:            lim.one_low_max            = cfg_wdata_i;
          CFG_ZERO_LOW_MAX:           lim.zero_low_max           = cfg_wdata_i;
          CFG_ONE_RECOVERY_MAX:       lim.one_recovery_max       = cfg_wdata_i;
          CFG_ZERO_RECOVERY_MAX:      lim.zero_recovery_max      = cfg_wdata_i;
          CFG_ONE_STOP_RECOVERY_MAX:  lim.one_stop_recovery_max  = cfg_wdata_i;
          CFG_ZERO_STOP_RECOVERY_MAX: lim.zero_stop_recovery_max = cfg_wdata_i;
          CFG_MESSAGE_LENGTH:         lim.message_length         = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (line_i.valid && line_i.ready) decode_sample(line_i.data.line_level);
      if (byte_i.valid && byte_i.ready) begin
        if (decoded_bytes.size() == 0) begin
          fail_count_o++;
          $display("%0t: byte transfer with nothing expected, got byte %0h index %0h",
                   $time, byte_i.data.data_byte, byte_i.data.byte_index);
        end else begin
          want = decoded_bytes.pop_front();
          check_field("data_byte", want.data_byte, byte_i.data.data_byte);
          check_field("byte_index", 8'(want.byte_index), 8'(byte_i.data.byte_index));
          check_field("last_byte", 8'(want.last_byte), 8'(byte_i.data.last_byte));
          check_field("timing_error", 8'(want.timing_error), 8'(byte_i.data.timing_error));
        end
      end
    end
    pending_o = decoded_bytes.size();
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the single-wire pulse-width receiver: drives line samples as pulse
// trains under several limit settings, stalls the byte side and reports the verdict.
// Depends on swpwr_pkg, the channel interfaces, the receiver and swpwr_byte_checker.
`timescale 1ns / 1ps

module tb;
  import swpwr_pkg::*;

  typedef enum logic [2:0] {
    BIT_RANDOM,
    BIT_TIGHT,
    BIT_LOOSE,
    BIT_LONG_LOW,
    BIT_LONG_HIGH,
    BIT_MIXED
  } bit_shape_e;

  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    take_bytes = 1'b0;
  logic                    cfg_we;
  cfg_index_e              cfg_index;
  logic [CfgDataWidth-1:0] cfg_wdata;
  bit                      gaps_on    = 1'b1;
  cfg_t                    line_cfg   = CfgReset;
  int unsigned             samples_sent;
  int unsigned             bytes_taken;
  int unsigned             fail_count;
  int unsigned             pending_bytes;

  swpwr_in_if  line_ch();
  swpwr_out_if byte_ch();

  assign byte_ch.ready = take_bytes;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  single_wire_pulse_width_receiver_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (line_ch),
    .out_o       (byte_ch)
  );

  swpwr_byte_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .line_i       (line_ch),
    .byte_i       (byte_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_bytes)
  );

  always @(posedge clk_i) begin
    if (rst_ni && byte_ch.valid && byte_ch.ready) bytes_taken++;
    take_bytes <= !gaps_on || ($urandom_range(0, 99) >= 7);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic put_sample(input logic lvl);
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      line_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    line_ch.valid           <= 1'b1;
    line_ch.data.line_level <= lvl;
    do @(posedge clk_i); while (!line_ch.ready);
    samples_sent++;
  endtask

  task automatic hold_line(input logic lvl, input int unsigned n);
    repeat (n) put_sample(lvl);
  endtask

  // short spans only, with the ends of the range favored
  function automatic int unsigned pick_span(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    if (hi > lo + 40) hi = lo + 40;
    if (hi < lo) hi = lo;
    roll = $urandom_range(0, 9);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_bit(input logic v, input int unsigned pos, input bit_shape_e shape);
    int unsigned lo_min, lo_max, hi_max, low_t, high_t;
    if (v) begin
      lo_min = 1;
      lo_max = 32'(line_cfg.one_low_max);
    end else begin
      lo_min = 32'(line_cfg.one_low_max) + 1;
      lo_max = 32'(line_cfg.zero_low_max);
    end
    if (lo_max < lo_min) lo_max = lo_min;
    if (pos == 7) begin
      hi_max = 32'(v ? line_cfg.one_stop_recovery_max : line_cfg.zero_stop_recovery_max);
    end else begin
      hi_max = 32'(v ? line_cfg.one_recovery_max : line_cfg.zero_recovery_max);
    end
    if (hi_max == 0) hi_max = 1;
    low_t  = pick_span(lo_min, lo_max);
    high_t = pick_span(1, hi_max);
    case (shape)
      BIT_TIGHT: begin
        low_t  = lo_min;
        high_t = 1;
      end
      BIT_LOOSE: begin
        low_t  = lo_max;
        high_t = hi_max;
      end
      BIT_LONG_LOW: begin
        low_t = 32'((line_cfg.one_low_max > line_cfg.zero_low_max) ?
                    line_cfg.one_low_max : line_cfg.zero_low_max) + 1 + $urandom_range(0, 3);
      end
      BIT_LONG_HIGH: high_t = hi_max + 1 + $urandom_range(0, 3);
      default: ;
    endcase
    hold_line(1'b0, low_t);
    hold_line(1'b1, high_t);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit_shape_e shape,
                           input int unsigned hurt_pos = 8,
                           input bit_shape_e hurt_shape = BIT_RANDOM);
    bit_shape_e  s;
    int unsigned roll;
    for (int unsigned i = 0; i < 8; i++) begin
      s = (i == hurt_pos) ? hurt_shape : shape;
      if (s == BIT_MIXED) begin
        roll = $urandom_range(0, 199);
        if (roll < 5) s = BIT_LONG_LOW;
        else if (roll < 10) s = BIT_LONG_HIGH;
        else if (roll < 25) s = BIT_TIGHT;
        else if (roll < 40) s = BIT_LOOSE;
        else s = BIT_RANDOM;
      end
      send_bit(b[i], i, s);
    end
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  task automatic program_limits(input cfg_t c, input logic [10:0] len_pad = '0);
    write_reg(CFG_ONE_LOW_MAX, c.one_low_max);
    write_reg(CFG_ZERO_LOW_MAX, c.zero_low_max);
    write_reg(CFG_ONE_RECOVERY_MAX, c.one_recovery_max);
    write_reg(CFG_ZERO_RECOVERY_MAX, c.zero_recovery_max);
    write_reg(CFG_ONE_STOP_RECOVERY_MAX, c.one_stop_recovery_max);
    write_reg(CFG_ZERO_STOP_RECOVERY_MAX, c.zero_stop_recovery_max);
    write_reg(CFG_MESSAGE_LENGTH, {len_pad, c.message_length});
    cfg_we   <= 1'b0;
    line_cfg  = c;
  endtask

  // small limits keep bits a few samples long so bytes come often
  function automatic cfg_t random_limits();
    cfg_t c;
    c.one_low_max = 16'($urandom_range(1, 4));
    if ($urandom_range(0, 9) == 0) begin
      c.zero_low_max = 16'($urandom_range(1, 32'(c.one_low_max)));
    end else begin
      c.zero_low_max = 16'(32'(c.one_low_max) + $urandom_range(1, 6));
    end
    c.one_recovery_max       = 16'($urandom_range(1, 8));
    c.zero_recovery_max      = 16'($urandom_range(1, 8));
    c.one_stop_recovery_max  = 16'($urandom_range(1, 12));
    c.zero_stop_recovery_max = 16'($urandom_range(1, 12));
    if ($urandom_range(0, 4) == 0) begin
      c.message_length = 5'($urandom_range(0, 31));
    end else begin
      c.message_length = 5'($urandom_range(1, 16));
    end
    return c;
  endfunction

  // hold the line high past every recovery limit so the last byte completes, then drain
  task automatic close_phase();
    int unsigned tail;
    tail = 32'(line_cfg.one_recovery_max);
    if (32'(line_cfg.zero_recovery_max) > tail) tail = 32'(line_cfg.zero_recovery_max);
    if (32'(line_cfg.one_stop_recovery_max) > tail) tail = 32'(line_cfg.one_stop_recovery_max);
    if (32'(line_cfg.zero_stop_recovery_max) > tail) begin
      tail = 32'(line_cfg.zero_stop_recovery_max);
    end
    hold_line(1'b1, tail + 2);
    line_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_bytes != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int unsigned sample_goal, input int unsigned byte_goal);
    int unsigned sample_base, byte_base, roll;
    sample_base = samples_sent;
    byte_base   = bytes_taken;
    while (samples_sent - sample_base < sample_goal || bytes_taken - byte_base < byte_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        repeat ($urandom_range(1, 12)) put_sample(1'($urandom_range(0, 1)));
      end else if (roll < 8) begin
        hold_line(1'b1, $urandom_range(1, 24));
      end else begin
        send_byte(8'($urandom_range(0, 255)), BIT_MIXED);
      end
    end
  endtask

  initial begin
    line_ch.valid <= 1'b0;
    line_ch.data  <= '{line_level: 1'b1};
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ONE_LOW_MAX;
    cfg_wdata     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // limits straight out of reset
    hold_line(1'b1, 3);
    send_byte(8'h6C, BIT_TIGHT);
    close_phase();

    // narrowest limits, two-byte messages, errors in a low and in a stop recovery
    program_limits('{one_low_max: 16'd1, zero_low_max: 16'd2, one_recovery_max: 16'd1,
                     zero_recovery_max: 16'd1, one_stop_recovery_max: 16'd1,
                     zero_stop_recovery_max: 16'd1, message_length: 5'd2});
    send_byte(8'hFF, BIT_LOOSE);
    send_byte(8'h00, BIT_LOOSE);
    send_byte(8'hA5, BIT_TIGHT, 2, BIT_LONG_LOW);
    send_byte(8'h5A, BIT_TIGHT);
    send_byte(8'hC3, BIT_TIGHT, 7, BIT_LONG_HIGH);
    send_byte(8'h3C, BIT_LOOSE);
    close_phase();

    // equal low limits leave no room for a zero, length 0 acts as 1
    program_limits('{one_low_max: 16'd3, zero_low_max: 16'd3, one_recovery_max: 16'd2,
                     zero_recovery_max: 16'd2, one_stop_recovery_max: 16'd3,
                     zero_stop_recovery_max: 16'd3, message_length: 5'd0});
    send_byte(8'h0F, BIT_RANDOM);
    send_byte(8'hF0, BIT_LOOSE);
    close_phase();

    // all limits zero, length above the maximum
    program_limits('{one_low_max: 16'd0, zero_low_max: 16'd0, one_recovery_max: 16'd0,
                     zero_recovery_max: 16'd0, one_stop_recovery_max: 16'd0,
                     zero_stop_recovery_max: 16'd0, message_length: 5'd17});
    send_byte(8'hA5, BIT_TIGHT);
    hold_line(1'b0, 3);
    close_phase();

    // widest zero low limit, wide recovery, length word with its unused upper bits set
    program_limits('{one_low_max: 16'd1, zero_low_max: 16'hFFFF, one_recovery_max: 16'd256,
                     zero_recovery_max: 16'd256, one_stop_recovery_max: 16'd256,
                     zero_stop_recovery_max: 16'd256, message_length: 5'd16}, 11'h7FF);
    send_byte(8'h96, BIT_RANDOM);
    send_byte(8'h69, BIT_TIGHT);
    close_phase();

    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      gaps_on = (phase_no != 1);
      program_limits(random_limits());
      random_traffic(200, 5);
      close_phase();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
